>>> design/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 20;

  // Configuration register.
  localparam int                 CFG_W             = 5;
  localparam logic [CFG_W-1:0]   FRAMES_IN_USE_RST = 5'd16;

  // Fixed result field widths.
  localparam int FRAME_FIELD_W = 4;
  localparam int EVICT_FIELD_W = 20;
  localparam int FAULT_W       = 32;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Back-end sequencer states.
  typedef enum logic {
    ST_SEARCH,
    ST_APPLY
  } lrupr_state_t;

  // One result transaction.
  typedef struct packed {
    logic                     hit;
    logic [FRAME_FIELD_W-1:0] frame_used;
    logic                     evicted_valid;
    logic [EVICT_FIELD_W-1:0] evicted_page;
    logic [FAULT_W-1:0]       fault_total;
  } lrupr_result_t;

endpackage

>>> design/lru_page_replacement.sv
// Top level of the LRU page replacement block: ports, frame-count register and wiring.
`timescale 1ns / 1ps

// Channel   Direction  Signals                      Contents
// s_*       in         s_tvalid s_tready s_tdata    page_number
// m_*       out        m_tvalid m_tready m_tdata    frame_used, evicted_page, fault_total
//                      m_tuser                      hit, evicted_valid
// cfg_*     in         cfg_we cfg_wdata             frames_in_use
//
// Each reference passes through the back-end states ST_SEARCH, for the parallel tag compare,
// empty-frame search and oldest-frame tree, and ST_APPLY, for the rank and table update.
// A two-entry queue decouples input acceptance from the back end, and a result
// register lets the next reference be searched while a result waits.
// Reset is synchronous and clears the queue, valid bits, ranks and fault counter at once.

module lru_page_replacement #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]     cfg_wdata,   // frames_in_use
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0]  s_tdata,     // page_number
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [55:0]                     m_tdata,     // frame_used, evicted_page, fault_total
  output logic [1:0]                      m_tuser      // hit, evicted_valid
);

  localparam int NW = ($clog2(FRAMES + 1) > lrupr_pkg::CFG_W) ?
                      $clog2(FRAMES + 1) : lrupr_pkg::CFG_W;

  logic [lrupr_pkg::CFG_W-1:0] frames_in_use;
  logic [NW-1:0]               active_n;
  logic                        head_valid;
  logic [PAGE_BITS-1:0]        head_page;
  logic                        pop;
  lrupr_pkg::lrupr_result_t    result;

  // Frame-count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrupr_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // Zero acts as one frame, values above the table size as the full table.
  always_comb begin
    if (frames_in_use == '0) begin
      active_n = NW'(1);
    end else if (NW'(frames_in_use) > NW'(FRAMES)) begin
      active_n = NW'(FRAMES);
    end else begin
      active_n = NW'(frames_in_use);
    end
  end

  lrupr_front #(
    .PAGE_BITS (PAGE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_page    (s_tdata[PAGE_BITS-1:0]),
    .head_valid (head_valid),
    .head_page  (head_page),
    .pop        (pop)
  );

  lrupr_back #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .NW        (NW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .active_n   (active_n),
    .head_valid (head_valid),
    .head_page  (head_page),
    .pop        (pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_result (result)
  );

  // Result packing.
  assign m_tdata = {result.fault_total, result.evicted_page, result.frame_used};
  assign m_tuser = {result.evicted_valid, result.hit};

endmodule

>>> design/lrupr_front.sv
// Front end: accepts page references into a short queue for the back end.
`timescale 1ns / 1ps

module lrupr_front #(
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PAGE_BITS-1:0] in_page,
  output logic                 head_valid,
  output logic [PAGE_BITS-1:0] head_page,
  input  logic                 pop
);

  localparam int PW = $clog2(lrupr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(lrupr_pkg::QUEUE_DEPTH + 1);

  logic [PAGE_BITS-1:0] queue_mem [lrupr_pkg::QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [CW-1:0]        count;
  logic                 push;
  logic                 take;

  // Handshake on both sides of the queue.
  assign in_ready   = (count != CW'(lrupr_pkg::QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign head_valid = (count != '0);
  assign take       = pop && head_valid;
  assign head_page  = queue_mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= in_page;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !take) begin
        count <= count + CW'(1);
      end else if (take && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> design/lrupr_back.sv
// Back end: frame table, recency ranks, fault counter and result register.
`timescale 1ns / 1ps

module lrupr_back #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
  parameter int NW        = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [NW-1:0]            active_n,
  input  logic                     head_valid,
  input  logic [PAGE_BITS-1:0]     head_page,
  output logic                     pop,
  input  logic                     out_ready,
  output logic                     out_valid,
  output lrupr_pkg::lrupr_result_t out_result
);

  localparam int              IW       = $clog2(FRAMES);
  localparam int              P        = 2 ** IW;
  localparam logic [IW-1:0]   RANK_MAX = IW'(FRAMES - 1);

  // Frame table state.
  logic [PAGE_BITS-1:0] frame_page   [FRAMES];
  logic                 frame_valid  [FRAMES];
  logic [IW-1:0]        recency_rank [FRAMES];
  logic [lrupr_pkg::FAULT_W-1:0] fault_counter;
  logic [lrupr_pkg::FAULT_W-1:0] fault_next;

  // Sequencer.
  lrupr_pkg::lrupr_state_t state;
  lrupr_pkg::lrupr_state_t state_next;
  logic                    apply;

  // Search results held for the update cycle.
  logic                 hit_q;
  logic                 ev_q;
  logic [IW-1:0]        target_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [IW-1:0]        hit_rank;

  // Search logic.
  logic          match_found;
  logic [IW-1:0] match_idx;
  logic          empty_found;
  logic [IW-1:0] empty_idx;
  logic [IW-1:0] node_rank [2*P-1];
  logic [IW-1:0] node_idx  [2*P-1];

  // Lowest active frame that holds the page, and lowest active empty frame.
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (NW'(k) < active_n) begin
        if (frame_valid[k] && (frame_page[k] == head_page)) begin
          match_found = 1'b1;
          match_idx   = IW'(k);
        end
        if (!frame_valid[k]) begin
          empty_found = 1'b1;
          empty_idx   = IW'(k);
        end
      end
    end
  end

  // Oldest-frame tree; inactive frames enter with rank zero and ties keep the lower index.
  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < FRAMES) begin : g_real
      assign node_rank[P-1+i] = (NW'(i) < active_n) ? recency_rank[i] : '0;
    end else begin : g_pad
      assign node_rank[P-1+i] = '0;
    end
    assign node_idx[P-1+i] = IW'(i);
  end

  for (genvar j = 0; j < P - 1; j++) begin : g_node
    assign node_rank[j] = (node_rank[2*j+2] > node_rank[2*j+1]) ?
                          node_rank[2*j+2] : node_rank[2*j+1];
    assign node_idx[j]  = (node_rank[2*j+2] > node_rank[2*j+1]) ?
                          node_idx[2*j+2] : node_idx[2*j+1];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lrupr_pkg::ST_SEARCH: begin
        if (head_valid) begin
          state_next = lrupr_pkg::ST_APPLY;
        end
      end
      lrupr_pkg::ST_APPLY: begin
        if (!out_valid || out_ready) begin
          state_next = lrupr_pkg::ST_SEARCH;
        end
      end
      default: state_next = lrupr_pkg::ST_SEARCH;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop   = 1'b0;
    apply = 1'b0;
    unique case (state)
      lrupr_pkg::ST_SEARCH: pop   = head_valid;
      lrupr_pkg::ST_APPLY:  apply = !out_valid || out_ready;
      default: begin
        pop   = 1'b0;
        apply = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrupr_pkg::ST_SEARCH;
    end else begin
      state <= state_next;
    end
  end

  // Capture the classification of the reference at the head of the queue.
  always_ff @(posedge clk) begin
    if (pop) begin
      page_q <= head_page;
      hit_q  <= match_found;
      ev_q   <= !match_found && !empty_found;
      if (match_found) begin
        target_q <= match_idx;
      end else if (empty_found) begin
        target_q <= empty_idx;
      end else begin
        target_q <= node_idx[0];
      end
    end
  end

  assign hit_rank   = recency_rank[target_q];
  assign fault_next = (!hit_q && (fault_counter != '1)) ?
                      fault_counter + lrupr_pkg::FAULT_W'(1) : fault_counter;

  // Frame table update: target made most recent; others age, on a hit only newer ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FRAMES; k++) begin
        frame_valid[k]  <= 1'b0;
        recency_rank[k] <= '0;
      end
      fault_counter <= '0;
    end else if (apply) begin
      for (int k = 0; k < FRAMES; k++) begin
        if ((NW'(k) < active_n) && frame_valid[k] && (IW'(k) != target_q)) begin
          if ((!hit_q || (recency_rank[k] < hit_rank)) && (recency_rank[k] != RANK_MAX)) begin
            recency_rank[k] <= recency_rank[k] + IW'(1);
          end
        end
      end
      recency_rank[target_q] <= '0;
      frame_valid[target_q]  <= 1'b1;
      fault_counter          <= fault_next;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      frame_page[target_q] <= page_q;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (apply) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_result.hit           <= hit_q;
      out_result.frame_used    <= lrupr_pkg::FRAME_FIELD_W'(target_q);
      out_result.evicted_valid <= ev_q;
      out_result.evicted_page  <= ev_q ?
                                  lrupr_pkg::EVICT_FIELD_W'(frame_page[target_q]) : '0;
      out_result.fault_total   <= fault_next;
    end
  end

`ifndef SYNTH
  // The frame just written holds a page afterwards.
  a_target_valid: assert property (@(posedge clk) disable iff (rst)
    apply |=> frame_valid[$past(target_q)])
    else $error("updated frame not marked valid");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_result.hit && out_result.evicted_valid))
    else $error("hit result carries an eviction");

  // A fault below saturation counts by exactly one.
  a_fault_count: assert property (@(posedge clk) disable iff (rst)
    (apply && !hit_q && (fault_counter != '1)) |=>
      (fault_counter == $past(fault_counter) + lrupr_pkg::FAULT_W'(1)))
    else $error("fault counter did not advance");

  // A new reference is taken only when no update is pending.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    apply |-> !pop)
    else $error("reference taken during update");
`endif

endmodule
